FILE: sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants for the circular deque
// Action codes, the input and result word layouts and the per-cell control
// struct that the top level hands to every cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  // action codes carried in the input word
  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_REAR  = 3'd1,
    ACT_DEL_FRONT = 3'd2,
    ACT_DEL_REAR  = 3'd3,
    ACT_NONE      = 3'd4
  } action_t;

  // width of the capacity register
  localparam int unsigned CAP_W = 5;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // front and rear value reported while the deque is empty
  localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

  // input word
  typedef struct packed {
    action_t            action;
    logic signed [31:0] value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic               ok;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic               is_empty;
    logic               is_full;
  } out_word_t;

  // one-cycle commands broadcast to every cell
  typedef struct packed {
    logic clear;
    logic ins_front;
    logic ins_rear;
    logic del_front;
    logic del_rear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/cdq_cell.sv
// ----------------------------------------------------------------------------
// cdq_cell: one position of the deque chain
// Holds one value and an occupied flag. Front inserts shift the chain toward
// the rear, front deletes shift it toward the front; rear operations touch
// only the cell at the boundary between occupied and free cells.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire cdq_pkg::cell_ctrl_t    ctrl,
  input  wire        [DATA_WIDTH-1:0] ins_data,
  input  wire        [DATA_WIDTH-1:0] left_data,
  input  wire                         left_occ,
  input  wire        [DATA_WIDTH-1:0] right_data,
  input  wire                         right_occ,
  output logic       [DATA_WIDTH-1:0] data,
  output logic                        occ
);

  logic [DATA_WIDTH-1:0] data_next;
  logic                  occ_next;
  logic                  first_free;
  logic                  last_held;

  // boundary positions of the occupied run
  assign first_free = !occ && left_occ;
  assign last_held  = occ && !right_occ;

  // next contents of this cell
  always_comb begin
    data_next = data;
    occ_next  = occ;
    if (ctrl.clear) begin
      occ_next = 1'b0;
    end else if (ctrl.ins_front) begin
      data_next = left_data;
      occ_next  = left_occ;
    end else if (ctrl.ins_rear) begin
      if (first_free) begin
        data_next = ins_data;
        occ_next  = 1'b1;
      end
    end else if (ctrl.del_front) begin
      data_next = right_data;
      occ_next  = right_occ;
    end else if (ctrl.del_rear) begin
      if (last_held) begin
        occ_next = 1'b0;
      end
    end
  end

  // occupied flag
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  // held value
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

FILE: sv/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue of signed values
// A chain of cells keeps the deque in order, front at cell 0. Each word
// inserts or deletes at either end, or does nothing, and returns one result
// word with success, front and rear values and empty and full flags.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake          payload
//   -------   ---------   ----------------   ----------------------------
//   in        input       in_valid/in_stall  in_word  (action, value)
//   out       output      out_valid/out_stall out_word (ok, front, rear, flags)
//   cfg       input       cfg_we             cfg_data (capacity)
//
// one word per cycle while in_stall is low: every cell updates from its neighbors at once.
// the result is built from the registered chain state and a registered ok flag; the input
// stalls only while a result waits and the output is stalled.
// rst (synchronous) empties the chain and sets capacity to 16.
// a capacity write empties the deque.
`default_nettype none

module circular_deque #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire cdq_pkg::in_word_t        in_word,
  output logic                          out_valid,
  input  wire                           out_stall,
  output cdq_pkg::out_word_t            out_word,
  input  wire                           cfg_we,
  input  wire   [cdq_pkg::CAP_W-1:0]    cfg_data
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > cdq_pkg::CAP_W) ? CNT_W : cdq_pkg::CAP_W;

  logic [cdq_pkg::CAP_W-1:0] capacity;
  logic [CNT_W-1:0]          held_count;
  logic [CNT_W-1:0]          held_count_next;
  logic [CMP_W-1:0]          cap_eff;
  logic [CMP_W-1:0]          count_ext;
  logic                      accept;
  logic                      has_room;
  logic                      has_item;
  logic                      ok_now;
  logic                      ok;
  cdq_pkg::cell_ctrl_t       ctrl;
  logic [DATA_WIDTH-1:0]     ins_data;
  logic [DATA_WIDTH-1:0]     cell_data  [DEPTH];
  logic                      cell_occ   [DEPTH];
  logic [DATA_WIDTH-1:0]     left_data  [DEPTH];
  logic                      left_occ   [DEPTH];
  logic [DATA_WIDTH-1:0]     right_data [DEPTH];
  logic                      right_occ  [DEPTH];
  logic [DATA_WIDTH-1:0]     rear_raw;
  logic [31:0]               front_out;
  logic [31:0]               rear_out;

  // handshake
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // capacity in force: zero acts as one, large values clamp to depth
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end else begin
      cap_eff = CMP_W'(capacity);
    end
  end

  assign count_ext = CMP_W'(held_count);
  assign has_room  = count_ext < cap_eff;
  assign has_item  = held_count != '0;

  // success of the incoming word
  always_comb begin
    case (in_word.action)
      cdq_pkg::ACT_INS_FRONT: ok_now = has_room;
      cdq_pkg::ACT_INS_REAR:  ok_now = has_room;
      cdq_pkg::ACT_DEL_FRONT: ok_now = has_item;
      cdq_pkg::ACT_DEL_REAR:  ok_now = has_item;
      cdq_pkg::ACT_NONE:      ok_now = 1'b1;
      default:                ok_now = 1'b0;
    endcase
  end

  // commands to the chain
  always_comb begin
    ctrl           = '0;
    ctrl.clear     = cfg_we;
    ctrl.ins_front = accept && ok_now && (in_word.action == cdq_pkg::ACT_INS_FRONT);
    ctrl.ins_rear  = accept && ok_now && (in_word.action == cdq_pkg::ACT_INS_REAR);
    ctrl.del_front = accept && ok_now && (in_word.action == cdq_pkg::ACT_DEL_FRONT);
    ctrl.del_rear  = accept && ok_now && (in_word.action == cdq_pkg::ACT_DEL_REAR);
  end

  // held count
  always_comb begin
    held_count_next = held_count;
    if (ctrl.clear) begin
      held_count_next = '0;
    end else if (ctrl.ins_front || ctrl.ins_rear) begin
      held_count_next = held_count + CNT_W'(1);
    end else if (ctrl.del_front || ctrl.del_rear) begin
      held_count_next = held_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      capacity   <= cdq_pkg::CAP_RESET;
    end else begin
      held_count <= held_count_next;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
    end
  end

  // stored value width and result value width
  generate
    if (DATA_WIDTH > 32) begin : g_wide
      assign ins_data  = {{(DATA_WIDTH-32){1'b0}}, in_word.value};
      assign front_out = cell_data[0][31:0];
      assign rear_out  = rear_raw[31:0];
    end else if (DATA_WIDTH == 32) begin : g_exact
      assign ins_data  = in_word.value;
      assign front_out = cell_data[0];
      assign rear_out  = rear_raw;
    end else begin : g_narrow
      assign ins_data  = in_word.value[DATA_WIDTH-1:0];
      assign front_out = {{(32-DATA_WIDTH){cell_data[0][DATA_WIDTH-1]}}, cell_data[0]};
      assign rear_out  = {{(32-DATA_WIDTH){rear_raw[DATA_WIDTH-1]}}, rear_raw};
    end
  endgenerate

  // neighbor wiring of the chain
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign left_data[i] = ins_data;
        assign left_occ[i]  = 1'b1;
      end else begin : g_mid
        assign left_data[i] = cell_data[i-1];
        assign left_occ[i]  = cell_occ[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
        assign right_data[i] = '0;
        assign right_occ[i]  = 1'b0;
      end else begin : g_body
        assign right_data[i] = cell_data[i+1];
        assign right_occ[i]  = cell_occ[i+1];
      end

      cdq_cell #(
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .ins_data   (ins_data),
        .left_data  (left_data[i]),
        .left_occ   (left_occ[i]),
        .right_data (right_data[i]),
        .right_occ  (right_occ[i]),
        .data       (cell_data[i]),
        .occ        (cell_occ[i])
      );
    end
  endgenerate

  // rear value: the one occupied cell whose right neighbor is free
  always_comb begin
    rear_raw = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_occ[i] && !right_occ[i]) begin
        rear_raw = rear_raw | cell_data[i];
      end
    end
  end

  // result valid and success flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok <= ok_now;
    end
  end

  // result word, taken from the state the word left behind
  always_comb begin
    out_word.ok          = ok;
    out_word.is_empty    = !has_item;
    out_word.is_full     = !has_room;
    out_word.front_value = has_item ? front_out : cdq_pkg::EMPTY_VALUE;
    out_word.rear_value  = has_item ? rear_out  : cdq_pkg::EMPTY_VALUE;
  end

endmodule

`default_nettype wire
